### rtl/core/tpss_pkg.sv
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared types and constants for the touch panel sample sequencer: beat
// structs, phase encoding, converter command bytes and register indexes.
// ----------------------------------------------------------------------------
package tpss_pkg;

    // default number of averaged x/y pairs
    localparam int DEF_SAMPLES = 4;

    // request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    // converter control bytes
    localparam logic [7:0] CMD_Z1 = 8'hB1;
    localparam logic [7:0] CMD_Z2 = 8'hC1;
    localparam logic [7:0] CMD_X  = 8'hD1;
    localparam logic [7:0] CMD_Y  = 8'h91;

    // full-scale offset used in the pressure formula
    localparam logic [15:0] ADC_FULL = 16'd4096;

    // configuration register indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    // configuration reset values
    localparam logic [12:0] THRESHOLD_RST = 13'd600;
    localparam logic [15:0] WIDTH_RST     = 16'd320;
    localparam logic [15:0] HEIGHT_RST    = 16'd240;

    // read sequence phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_Z1      = 3'd1,
        PH_Z2      = 3'd2,
        PH_DISCARD = 3'd3,
        PH_X       = 3'd4,
        PH_Y       = 3'd5
    } phase_t;

    // input beat
    typedef struct packed {
        logic        opcode;
        logic [15:0] reading;
    } request_t;

    // output beat
    typedef struct packed {
        logic        command_valid;
        logic [7:0]  command;
        logic        report_valid;
        logic        touched;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] strength;
    } result_t;

endpackage

### rtl/core/touch_panel_sample_sequencer.sv
// ----------------------------------------------------------------------------
// touch_panel_sample_sequencer
// Steps through one resistive touch read (Z1, Z2, a discarded X, then
// SAMPLES x/y pairs), tells which converter command to send next, and
// reports pressure plus the scaled, averaged position.
// ----------------------------------------------------------------------------
// Usage: busy is always low, so a beat can be issued with start on every
// clock. Every beat gives exactly one result. The result is on the result
// ports with done high for one cycle. Results leave in issue order. Each
// beat passes through the input register, one stage for the phase update,
// one for the 17x16 scale multiply, one for the split reciprocal multiply
// of the exact divide by 4096*SAMPLES, and the result register, which also
// does the final add and shift. The receiver cannot stall, so done must be
// sampled when it appears. Registers must be written by the user only while
// no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_panel_sample_sequencer #(
    parameter int SAMPLES = tpss_pkg::DEF_SAMPLES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tpss_pkg::request_t request,
    output logic              done,
    output tpss_pkg::result_t result,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [15:0]       wr_data
);
    import tpss_pkg::*;

    // divide-by-SAMPLES via reciprocal; quotient input is 21 bits
    localparam int QW          = 21;
    localparam int LoW         = 11;
    localparam int HiW         = QW - LoW;
    localparam int RW          = QW + 1;
    localparam int LoProdW     = LoW + RW;
    localparam int HiProdW     = HiW + RW;
    localparam int FullW       = QW + RW + 1;
    localparam int DivShift    = $clog2(SAMPLES);
    localparam int RecipShift  = QW + DivShift;
    localparam logic [63:0] RecipFull =
        ((64'd1 << RecipShift) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
    localparam logic [RW-1:0] Recip = RecipFull[RW-1:0];

    logic accept;

    // configuration registers
    logic [12:0] threshold_reg;
    logic [15:0] width_max_reg;
    logic [15:0] height_max_reg;

    // sequence state
    phase_t      phase_reg, phase_next;
    logic [12:0] first_pressure_reg, first_pressure_next;
    logic [15:0] pressure_value_reg, pressure_value_next;
    logic [4:0]  pair_count_reg, pair_count_next;
    logic [19:0] x_sum_reg, x_sum_next;
    logic [19:0] y_sum_reg, y_sum_next;

    // pipeline valid bits and payload
    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    request_t    req_reg;
    result_t     s1_res_reg, s1_res_next;
    logic [16:0] s1_xs_reg, s1_xs_next;
    logic [16:0] s1_ys_reg, s1_ys_next;
    result_t     s2_res_reg;
    logic [QW-1:0] s2_qx_reg, s2_qy_reg;
    result_t     s3_res_reg;
    logic [LoProdW-1:0] s3_xlo_reg, s3_ylo_reg;
    logic [HiProdW-1:0] s3_xhi_reg, s3_yhi_reg;
    result_t     s4_res_reg, s4_res_next;

    logic [15:0] z_value;
    logic        under_thr;
    logic [4:0]  pair_inc;
    logic [32:0] x_prod, y_prod;
    logic [FullW-1:0] x_full, y_full;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            width_max_reg  <= WIDTH_RST;
            height_max_reg <= HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_THRESHOLD: threshold_reg  <= wr_data[12:0];
                REG_WIDTH:     width_max_reg  <= wr_data;
                REG_HEIGHT:    height_max_reg <= wr_data;
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    // pressure and pair bookkeeping
    assign z_value   = 16'({3'b0, first_pressure_reg} + ADC_FULL
                           - {3'b0, req_reg.reading[15:3]});
    assign under_thr = z_value < {3'b0, threshold_reg};
    assign pair_inc  = pair_count_reg + 5'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (v0_reg)
        begin
            if (req_reg.opcode == OP_START)
            begin
                phase_next = PH_Z1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_Z1:      phase_next = PH_Z2;
                    PH_Z2:      phase_next = under_thr ? PH_IDLE : PH_DISCARD;
                    PH_DISCARD: phase_next = PH_X;
                    PH_X:       phase_next = PH_Y;
                    PH_Y:       phase_next = (pair_inc < 5'(SAMPLES)) ? PH_X : PH_IDLE;
                    default:    phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // state data and result fields for the beat in the input register
    always_comb
    begin
        first_pressure_next = first_pressure_reg;
        pressure_value_next = pressure_value_reg;
        pair_count_next     = pair_count_reg;
        x_sum_next          = x_sum_reg;
        y_sum_next          = y_sum_reg;
        s1_res_next         = '0;
        s1_xs_next          = '0;
        s1_ys_next          = '0;
        if (v0_reg)
        begin
            if (req_reg.opcode == OP_START)
            begin
                pair_count_next           = '0;
                x_sum_next                = '0;
                y_sum_next                = '0;
                s1_res_next.command_valid = 1'b1;
                s1_res_next.command       = CMD_Z1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_Z1:
                    begin
                        first_pressure_next       = req_reg.reading[15:3];
                        s1_res_next.command_valid = 1'b1;
                        s1_res_next.command       = CMD_Z2;
                    end
                    PH_Z2:
                    begin
                        pressure_value_next = z_value;
                        if (under_thr)
                        begin
                            s1_res_next.report_valid = 1'b1;
                            s1_res_next.strength     = z_value;
                        end
                        else
                        begin
                            s1_res_next.command_valid = 1'b1;
                            s1_res_next.command       = CMD_X;
                        end
                    end
                    PH_DISCARD:
                    begin
                        pair_count_next           = '0;
                        x_sum_next                = '0;
                        y_sum_next                = '0;
                        s1_res_next.command_valid = 1'b1;
                        s1_res_next.command       = CMD_X;
                    end
                    PH_X:
                    begin
                        x_sum_next                = x_sum_reg + 20'(req_reg.reading);
                        s1_res_next.command_valid = 1'b1;
                        s1_res_next.command       = CMD_Y;
                    end
                    PH_Y:
                    begin
                        y_sum_next      = y_sum_reg + 20'(req_reg.reading);
                        pair_count_next = pair_inc;
                        if (pair_inc < 5'(SAMPLES))
                        begin
                            s1_res_next.command_valid = 1'b1;
                            s1_res_next.command       = CMD_X;
                        end
                        else
                        begin
                            s1_res_next.report_valid = 1'b1;
                            s1_res_next.touched      = 1'b1;
                            s1_res_next.strength     = pressure_value_reg;
                            s1_xs_next               = x_sum_reg[19:3];
                            s1_ys_next               = y_sum_next[19:3];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            first_pressure_reg <= '0;
            pressure_value_reg <= '0;
            pair_count_reg     <= '0;
            x_sum_reg          <= '0;
            y_sum_reg          <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            first_pressure_reg <= first_pressure_next;
            pressure_value_reg <= pressure_value_next;
            pair_count_reg     <= pair_count_next;
            x_sum_reg          <= x_sum_next;
            y_sum_reg          <= y_sum_next;
        end
    end

    // scale multiply, then drop the 4096 factor
    assign x_prod = 33'(s1_xs_reg) * 33'(width_max_reg);
    assign y_prod = 33'(s1_ys_reg) * 33'(height_max_reg);

    // final add and shift of the split reciprocal products
    assign x_full = (FullW'(s3_xhi_reg) << LoW) + FullW'(s3_xlo_reg);
    assign y_full = (FullW'(s3_yhi_reg) << LoW) + FullW'(s3_ylo_reg);

    // result beat with the scaled position filled in
    always_comb
    begin
        s4_res_next       = s3_res_reg;
        s4_res_next.x_pos = 16'(x_full >> RecipShift);
        s4_res_next.y_pos = 16'(y_full >> RecipShift);
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_res_reg <= s1_res_next;
        s1_xs_reg  <= s1_xs_next;
        s1_ys_reg  <= s1_ys_next;

        s2_res_reg <= s1_res_reg;
        s2_qx_reg  <= x_prod[32:12];
        s2_qy_reg  <= y_prod[32:12];

        s3_res_reg <= s2_res_reg;
        s3_xlo_reg <= LoProdW'(s2_qx_reg[LoW-1:0]) * LoProdW'(Recip);
        s3_xhi_reg <= HiProdW'(s2_qx_reg[QW-1:LoW]) * HiProdW'(Recip);
        s3_ylo_reg <= LoProdW'(s2_qy_reg[LoW-1:0]) * LoProdW'(Recip);
        s3_yhi_reg <= HiProdW'(s2_qy_reg[QW-1:LoW]) * HiProdW'(Recip);

        s4_res_reg <= s4_res_next;
    end

    assign done   = v4_reg;
    assign result = s4_res_reg;

    // every accepted beat comes out after a fixed latency
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("result did not follow accepted beat");

    // a result may ask for a command or close the read, never both
    a_cmd_or_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.command_valid && result.report_valid))
        else $error("command and report in one result");

    // position is zero unless the read was a touch
    a_pos_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.touched) |-> (result.x_pos == 16'd0 && result.y_pos == 16'd0))
        else $error("position reported without touch");

    // a start always restarts the sequence at the first pressure read
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && req_reg.opcode == OP_START) |=> (phase_reg == PH_Z1))
        else $error("start did not restart the sequence");

    // pair counter stays within the sample count
    a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg <= 5'(SAMPLES))
        else $error("pair counter overran");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for touch_panel_sample_sequencer. Runs directed reads
// (idle words, touched and untouched reads, restarts, register extremes), then
// random read sequences under several register settings. The bench predicts
// every result beat and checks it field by field.
// ----------------------------------------------------------------------------
module tb;
    import tpss_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [15:0] wr_data;

    // register copies
    logic [12:0] threshold_q;
    logic [15:0] width_q;
    logic [15:0] height_q;

    // read sequence copy
    phase_t      read_phase;
    logic [12:0] z1_q;
    logic [15:0] pressure_q;
    logic [4:0]  pair_cnt;
    logic [19:0] x_acc;
    logic [19:0] y_acc;

    result_t     pending_results[$];
    int          beats_sent;
    int          mismatches;
    int unsigned cycle_count;
    bit          gaps_on;

    touch_panel_sample_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // averaged position scaled to the screen size
    function automatic logic [15:0] scale_position(logic [19:0] sum, logic [15:0] span);
        logic [63:0] prod;
        prod = 64'(sum >> 3) * 64'(span);
        return 16'((prod / 64'(ADC_FULL)) / 64'(DEF_SAMPLES));
    endfunction

    // next result beat of the read sequence; advances the sequence copy
    function automatic result_t advance_read(request_t req);
        result_t r;
        r = '0;
        if (req.opcode == OP_START) begin
            read_phase = PH_Z1;
            pair_cnt = '0;
            x_acc = '0;
            y_acc = '0;
            r.command_valid = 1'b1;
            r.command = CMD_Z1;
        end
        else begin
            case (read_phase)
                PH_Z1: begin
                    z1_q = req.reading[15:3];
                    read_phase = PH_Z2;
                    r.command_valid = 1'b1;
                    r.command = CMD_Z2;
                end
                PH_Z2: begin
                    pressure_q = 16'(z1_q) + ADC_FULL - {3'b000, req.reading[15:3]};
                    if (pressure_q < {3'b000, threshold_q}) begin
                        read_phase = PH_IDLE;
                        r.report_valid = 1'b1;
                        r.strength = pressure_q;
                    end
                    else begin
                        read_phase = PH_DISCARD;
                        r.command_valid = 1'b1;
                        r.command = CMD_X;
                    end
                end
                PH_DISCARD: begin
                    pair_cnt = '0;
                    x_acc = '0;
                    y_acc = '0;
                    read_phase = PH_X;
                    r.command_valid = 1'b1;
                    r.command = CMD_X;
                end
                PH_X: begin
                    x_acc = x_acc + 20'(req.reading);
                    read_phase = PH_Y;
                    r.command_valid = 1'b1;
                    r.command = CMD_Y;
                end
                PH_Y: begin
                    y_acc = y_acc + 20'(req.reading);
                    pair_cnt = pair_cnt + 5'd1;
                    if (pair_cnt < DEF_SAMPLES) begin
                        read_phase = PH_X;
                        r.command_valid = 1'b1;
                        r.command = CMD_X;
                    end
                    else begin
                        read_phase = PH_IDLE;
                        r.report_valid = 1'b1;
                        r.touched = 1'b1;
                        r.x_pos = scale_position(x_acc, width_q);
                        r.y_pos = scale_position(y_acc, height_q);
                        r.strength = pressure_q;
                    end
                end
                default: read_phase = PH_IDLE;
            endcase
        end
        return r;
    endfunction

    // conversion word, extremes now and then
    function automatic logic [15:0] pick_reading();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // drive one beat from a falling edge, hold until taken, predict it
    task automatic send_beat(input request_t req);
        // each cycle idles with the same chance
        while (gaps_on && $urandom_range(0, 99) < 29) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy) begin
            @(negedge clk);
            @(posedge clk);
        end
        pending_results.push_back(advance_read(req));
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_start();
        send_beat('{opcode: OP_START, reading: 16'($urandom_range(0, 65535))});
    endtask

    task automatic send_word(input logic [15:0] value);
        send_beat('{opcode: OP_WORD, reading: value});
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // write all three registers on consecutive clocks while idle
    task automatic apply_config(input logic [15:0] thr, input logic [15:0] wid,
                                input logic [15:0] hgt);
        wr_en <= 1'b1;
        wr_index <= REG_THRESHOLD;
        wr_data <= thr;
        @(negedge clk);
        wr_index <= REG_WIDTH;
        wr_data <= wid;
        @(negedge clk);
        wr_index <= REG_HEIGHT;
        wr_data <= hgt;
        @(negedge clk);
        wr_en <= 1'b0;
        threshold_q = thr[12:0];
        width_q = wid;
        height_q = hgt;
        @(negedge clk);
    endtask

    // one read with random words; cut < 0 runs it to the report
    task automatic run_read(input int cut, input bit hard_press);
        int n;
        n = 0;
        send_start();
        if (hard_press) begin
            send_word(16'hFFFF);
            send_word(16'h0000);
            n = 2;
        end
        while (read_phase != PH_IDLE && n != cut) begin
            send_word(pick_reading());
            n++;
        end
    endtask

    task automatic test_idle_word();
        send_word(16'hFFFF);
    endtask

    // full-scale pressure and full-scale x/y on every sample
    task automatic test_full_touch();
        send_start();
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h1234);
        repeat (DEF_SAMPLES) begin
            send_word(16'hFFFF);
            send_word(16'hFFFF);
        end
        send_word(16'h0000);
    endtask

    // pressure just below, then exactly at the threshold
    task automatic test_pressure_edge();
        send_start();
        send_word(16'h0000);
        send_word(16'd27976);
        send_start();
        send_word(16'h0000);
        send_word(16'd27968);
        while (read_phase != PH_IDLE) send_word(pick_reading());
    endtask

    // start in the middle of a read abandons it
    task automatic test_restart();
        send_start();
        send_word(16'h8000);
        send_start();
        send_word(16'h7FFF);
        send_word(16'h0000);
        send_word(16'h5555);
        send_word(16'hAAAA);
        run_read(-1, 1'b0);
    endtask

    task automatic test_config_extremes();
        wait_drained();
        apply_config(16'd0, 16'hFFFF, 16'hFFFF);
        run_read(-1, 1'b1);
        run_read(-1, 1'b0);
        wait_drained();
        apply_config(16'd8191, 16'd1, 16'd1);
        run_read(-1, 1'b1);
        run_read(-1, 1'b0);
        wait_drained();
        // upper data bits dropped by the threshold register, zero screen size
        apply_config(16'hFFFF, 16'd0, 16'd0);
        run_read(-1, 1'b1);
        wait_drained();
        apply_config(16'(THRESHOLD_RST), WIDTH_RST, HEIGHT_RST);
        run_read(-1, 1'b1);
        wait_drained();
    endtask

    // mostly whole reads, some stray words and cut-short reads
    task automatic random_traffic(input int count);
        int goal;
        int pick;
        goal = beats_sent + count;
        while (beats_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_word(pick_reading());
            else if (pick < 16)
                run_read($urandom_range(0, 2 * DEF_SAMPLES + 2), 1'b0);
            else
                run_read(-1, 1'b0);
        end
    endtask

    task automatic test_random_reads();
        logic [15:0] thr;
        for (int ph_idx = 0; ph_idx < 4; ph_idx++) begin
            wait_drained();
            if ($urandom_range(0, 3) == 0)
                thr = 16'($urandom_range(0, 65535));
            else
                thr = 16'($urandom_range(0, 2000));
            apply_config(thr, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            // one phase runs back to back with no gaps
            gaps_on = (ph_idx != 2);
            random_traffic(60);
            wait_drained();
            random_traffic(60);
        end
        gaps_on = 1'b1;
    endtask

    // compare one field of a result beat
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge clk) begin : check_results
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else begin
                want = pending_results.pop_front();
                check_field("command_valid", 16'(want.command_valid), 16'(result.command_valid));
                check_field("command", 16'(want.command), 16'(result.command));
                check_field("report_valid", 16'(want.report_valid), 16'(result.report_valid));
                check_field("touched", 16'(want.touched), 16'(result.touched));
                check_field("x_pos", want.x_pos, result.x_pos);
                check_field("y_pos", want.y_pos, result.y_pos);
                check_field("strength", want.strength, result.strength);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("touch_panel_sample_sequencer verification failed");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        wr_en = 1'b0;
        wr_index = REG_THRESHOLD;
        wr_data = '0;
        threshold_q = THRESHOLD_RST;
        width_q = WIDTH_RST;
        height_q = HEIGHT_RST;
        read_phase = PH_IDLE;
        z1_q = '0;
        pressure_q = '0;
        pair_cnt = '0;
        x_acc = '0;
        y_acc = '0;
        beats_sent = 0;
        mismatches = 0;
        cycle_count = 0;
        gaps_on = 1'b1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_word();
        test_full_touch();
        test_pressure_edge();
        test_restart();
        test_config_extremes();
        test_random_reads();

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("touch_panel_sample_sequencer verification clean");
        else
            $display("touch_panel_sample_sequencer verification failed");
        $finish;
    end

endmodule
